### rtl/shvw_pkg.sv
// shvw_pkg: shared types and constants for the spatial hash vertex weld unit
// no dependencies
`timescale 1ns / 1ps
package shvw_pkg;

  localparam logic [31:0] PrimeX = 32'd73856093;
  localparam logic [31:0] PrimeY = 32'd19349663;
  localparam logic [31:0] PrimeZ = 32'd83492791;

  localparam int unsigned DataW = 96;   // three 32-bit positions, whole bytes
  localparam int unsigned OutW  = 32;   // 26 field bits padded to bytes
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW = 32;

  localparam logic [CfgIdxW-1:0] RegWeldDist = 2'd0;
  localparam logic [CfgIdxW-1:0] RegInvDist  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegBuckets  = 2'd2;

  localparam logic ReqAdd   = 1'b0;
  localparam logic ReqClear = 1'b1;

  // handshake between the top level and the modulo unit
  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctrl_t;

endpackage

### rtl/shvw_mod.sv
// shvw_mod: restoring bit-serial 32-bit by 32-bit remainder unit
// depends on shvw_pkg
`timescale 1ns / 1ps
module shvw_mod (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [31:0]         num_i,
  input  logic [31:0]         den_i,
  output shvw_pkg::div_ctrl_t ctrl_o,
  output logic [31:0]         rem_o
);

  logic [31:0] num_q, num_d;
  logic [31:0] den_q, den_d;
  logic [32:0] rem_q, rem_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [32:0] trial;

  // one quotient bit per cycle
  always_comb begin
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[31:0], num_q[31]};
    if (start_i) begin
      num_d  = num_i;
      den_d  = den_i;
      rem_d  = '0;
      cnt_d  = 6'd32;
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[30:0], 1'b0};
      if (trial >= {1'b0, den_q}) rem_d = trial - {1'b0, den_q};
      else rem_d = trial;
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign ctrl_o.start = start_i;
  assign ctrl_o.busy  = busy_q;
  assign ctrl_o.done  = done_q;
  assign rem_o = rem_q[31:0];

endmodule

### rtl/spatial_hash_vertex_weld_unit.sv
// spatial_hash_vertex_weld_unit: top level, hashing, chain walk and memories
// depends on shvw_pkg and shvw_mod
`timescale 1ns / 1ps
//
// channel   dir  tdata (low bit up)                          handshake
// s_axis    in   pos_x[31:0] pos_y pos_z, tuser=req_type        tvalid/tready
// m_axis    out  rep_index compact_index is_new full_error     tvalid/tready
// cfg       in   cfg_wdata_i at register cfg_index_i             cfg_we_i
//
// An add runs the multiply and hash states, the remainder unit (start, 32 steps,
// done), the bucket head read, then read, difference, square and compare per
// chain entry visited over the registered-read vertex memory, and a write when new.
// A clear sweeps every entry of the bucket memory; after reset the same
// sweep runs before the first word is accepted.
// One item at a time; the result waits in an output register and the next
// word is taken only once that register drains.
module spatial_hash_vertex_weld_unit #(
  parameter int unsigned MAX_VERTICES = 4096,
  parameter int unsigned MAX_BUCKETS  = 16384
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // pos_x, pos_y, pos_z
  input  logic [shvw_pkg::DataW-1:0]        s_axis_tdata,
  // req_type
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // rep_index, compact_index, is_new, full_error, zero pad
  output logic [shvw_pkg::OutW-1:0]         m_axis_tdata,
  input  logic                              cfg_we_i,
  input  logic [shvw_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [shvw_pkg::CfgW-1:0]         cfg_wdata_i
);

  localparam int unsigned VW = $clog2(MAX_VERTICES);
  localparam int unsigned BW = $clog2(MAX_BUCKETS);
  localparam int unsigned CW = VW + 1;

  typedef enum logic [3:0] {
    StClr, StIdle, StMul, StHash, StMod, StHead, StHeadRd, StRd, StDiff,
    StSq, StCmp, StNew, StOut
  } state_e;

  state_e state_q;

  // configuration
  logic [30:0] weld_q;
  logic [31:0] inv_q;
  logic [14:0] nbk_q;

  // memories
  logic [VW:0]  head_mem [MAX_BUCKETS];  // valid bit + index
  logic [VW:0]  link_mem [MAX_VERTICES];
  logic [31:0]  x_mem [MAX_VERTICES];
  logic [31:0]  y_mem [MAX_VERTICES];
  logic [31:0]  z_mem [MAX_VERTICES];
  logic [VW-1:0] rank_mem [MAX_VERTICES];

  logic [VW:0]   head_rd_q, link_rd_q;
  logic [31:0]   x_rd_q, y_rd_q, z_rd_q;
  logic [VW-1:0] rank_rd_q;

  logic [31:0]  px_q, py_q, pz_q;
  logic [63:0]  cx_q, cy_q, cz_q;
  logic [31:0]  hash_q;
  logic [BW-1:0] bkt_q;
  logic [BW:0]   clr_q;
  logic [VW-1:0] cur_q;
  logic [VW:0]   head_q;
  logic [CW-1:0] vcnt_q, kcnt_q;
  logic [32:0]  dx_q, dy_q, dz_q;
  logic [65:0]  sx_q, sy_q, sz_q;
  logic         far_q;
  logic [31:0]  nb;
  logic         div_start;
  shvw_pkg::div_ctrl_t div_ctrl;
  logic [31:0]  rem;
  logic         out_v_q;
  logic [VW-1:0] o_rep_q, o_rank_q;
  logic         o_new_q, o_full_q;

  // clamp of bucket count
  always_comb begin
    if (nbk_q == 15'd0) nb = 32'd1;
    else if ({17'd0, nbk_q} > 32'(MAX_BUCKETS)) nb = 32'(MAX_BUCKETS);
    else nb = {17'd0, nbk_q};
  end

  // start once the hash register holds this vertex's hash
  assign div_start = (state_q == StMod) && !div_ctrl.busy && !div_ctrl.done;

  shvw_mod u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (hash_q),
    .den_i  (nb),
    .ctrl_o (div_ctrl),
    .rem_o  (rem)
  );

  function automatic logic [32:0] absd(input logic [31:0] a, input logic [31:0] b);
    logic signed [32:0] d;
    d = $signed({a[31], a}) - $signed({b[31], b});
    absd = d[32] ? 33'(-d) : 33'(d);
  endfunction

  assign s_axis_tready = (state_q == StIdle) && !(out_v_q && !m_axis_tready);

  // memory writes and registered reads
  always_ff @(posedge clk_i) begin
    if (state_q == StClr) head_mem[clr_q[BW-1:0]] <= '0;
    if (state_q == StNew) begin
      head_mem[bkt_q] <= {1'b1, vcnt_q[VW-1:0]};
      link_mem[vcnt_q[VW-1:0]] <= head_q;
      x_mem[vcnt_q[VW-1:0]] <= px_q;
      y_mem[vcnt_q[VW-1:0]] <= py_q;
      z_mem[vcnt_q[VW-1:0]] <= pz_q;
      rank_mem[vcnt_q[VW-1:0]] <= kcnt_q[VW-1:0];
    end
    head_rd_q <= head_mem[bkt_q];
    link_rd_q <= link_mem[cur_q];
    x_rd_q <= x_mem[cur_q];
    y_rd_q <= y_mem[cur_q];
    z_rd_q <= z_mem[cur_q];
    rank_rd_q <= rank_mem[cur_q];
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == StIdle) begin
      px_q <= s_axis_tdata[31:0];
      py_q <= s_axis_tdata[63:32];
      pz_q <= s_axis_tdata[95:64];
    end
    if (state_q == StMul) begin
      cx_q <= $signed({{32{px_q[31]}}, px_q}) * $signed({32'd0, inv_q});
      cy_q <= $signed({{32{py_q[31]}}, py_q}) * $signed({32'd0, inv_q});
      cz_q <= $signed({{32{pz_q[31]}}, pz_q}) * $signed({32'd0, inv_q});
    end
    if (state_q == StHash)
      hash_q <= (cx_q[63:32] * shvw_pkg::PrimeX) ^ (cy_q[63:32] * shvw_pkg::PrimeY)
              ^ (cz_q[63:32] * shvw_pkg::PrimeZ);
    if (state_q == StMod && div_ctrl.done) bkt_q <= rem[BW-1:0];
    if (state_q == StDiff) begin
      dx_q <= absd(px_q, x_rd_q);
      dy_q <= absd(py_q, y_rd_q);
      dz_q <= absd(pz_q, z_rd_q);
    end
    if (state_q == StSq) begin
      far_q <= (dx_q > {2'd0, weld_q}) || (dy_q > {2'd0, weld_q})
            || (dz_q > {2'd0, weld_q});
      sx_q <= dx_q * dx_q;
      sy_q <= dy_q * dy_q;
      sz_q <= dz_q * dz_q;
    end
  end

  // control state machine and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StClr;
      clr_q    <= '0;
      weld_q   <= 31'd65536;
      inv_q    <= 32'd65536;
      nbk_q    <= 15'd8256;
      vcnt_q   <= '0;
      kcnt_q   <= '0;
      out_v_q  <= 1'b0;
      cur_q    <= '0;
      head_q   <= '0;
      o_rep_q  <= '0;
      o_rank_q <= '0;
      o_new_q  <= 1'b0;
      o_full_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          shvw_pkg::RegWeldDist: weld_q <= cfg_wdata_i[30:0];
          shvw_pkg::RegInvDist:  inv_q  <= cfg_wdata_i;
          shvw_pkg::RegBuckets:  nbk_q  <= cfg_wdata_i[14:0];
          default: ;
        endcase
      end
      if (out_v_q && m_axis_tready) out_v_q <= 1'b0;
      case (state_q)
        StClr: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q[BW-1:0] == BW'(MAX_BUCKETS - 1)) begin
            clr_q <= '0;
            state_q <= StIdle;
          end
        end
        StIdle: if (s_axis_tvalid && s_axis_tready) begin
          o_rep_q <= '0; o_rank_q <= '0; o_new_q <= 1'b0; o_full_q <= 1'b0;
          if (s_axis_tuser == shvw_pkg::ReqClear) begin
            vcnt_q <= '0;
            kcnt_q <= '0;
            out_v_q <= 1'b1;
            state_q <= StClr;
          end else if (vcnt_q >= CW'(MAX_VERTICES)) begin
            o_full_q <= 1'b1;
            out_v_q <= 1'b1;
          end else state_q <= StMul;
        end
        StMul:  state_q <= StHash;
        StHash: state_q <= StMod;
        StMod:  if (div_ctrl.done) state_q <= StHead;
        StHead: state_q <= StHeadRd;
        StHeadRd: begin
          head_q <= head_rd_q;
          cur_q <= head_rd_q[VW-1:0];
          state_q <= head_rd_q[VW] ? StRd : StNew;
        end
        StRd:   state_q <= StDiff;
        StDiff: state_q <= StSq;
        StSq:   state_q <= StCmp;
        StCmp: begin
          if (!far_q && ({2'd0, sx_q} + {2'd0, sy_q} + {2'd0, sz_q}
                         <= 68'({37'd0, weld_q} * {37'd0, weld_q}))) begin
            o_rep_q <= cur_q;
            o_rank_q <= rank_rd_q;
            vcnt_q <= vcnt_q + 1'b1;
            out_v_q <= 1'b1;
            state_q <= StIdle;
          end else if (link_rd_q[VW]) begin
            cur_q <= link_rd_q[VW-1:0];
            state_q <= StRd;
          end else state_q <= StNew;
        end
        StNew: begin
          o_rep_q <= vcnt_q[VW-1:0];
          o_rank_q <= kcnt_q[VW-1:0];
          o_new_q <= 1'b1;
          vcnt_q <= vcnt_q + 1'b1;
          kcnt_q <= kcnt_q + 1'b1;
          out_v_q <= 1'b1;
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata = {6'd0, o_full_q, o_new_q, 12'(o_rank_q), 12'(o_rep_q)};

  // a new item is only taken with the output register free or draining
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |-> !out_v_q || m_axis_tready)
    else $error("input taken while result stalled");
  // kept vertices never outnumber vertices added
  assert property (@(posedge clk_i) disable iff (!rst_ni) kcnt_q <= vcnt_q)
    else $error("kept count above vertex count");
  // the remainder unit runs only while waiting for the bucket
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_ctrl.busy |-> state_q == StMod)
    else $error("remainder unit busy outside bucket wait");

endmodule
